// ===== design/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssc_pkg: shared types and constants of the sphere collision block
// Step counts of the square-root and divider chains, register indexes and
// the side data that travels alongside the arithmetic cells.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 32;
  localparam int NumLanes  = 6;
  // Stages: difference, squares, sum and compare, sqrt cells, div cells, output.
  localparam int NumStages = 3 + SqrtSteps + DivSteps + 1;

  typedef enum logic [1:0] {
    CfgCentreX = 2'd0,
    CfgCentreY = 2'd1,
    CfgCentreZ = 2'd2,
    CfgRadius  = 2'd3
  } cfg_idx_e;

  // Data that rides along the square-root chain.
  typedef struct packed {
    logic             hit;
    logic [2:0]       neg;
    logic [2:0][63:0] prod;
    logic [2:0][32:0] mag;
  } sqrt_side_t;

  // Data that rides along the divider chain.
  typedef struct packed {
    logic       hit;
    logic [2:0] neg;
  } div_side_t;

endpackage

// ===== design/ssc_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// ssc_sqrt_cell: one digit step of the integer square root
// Takes two radicand bits, tries the next root bit and registers the result.
// ----------------------------------------------------------------------------
module ssc_sqrt_cell import ssc_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rad_i,
  input  logic [33:0] rem_i,
  input  logic [31:0] root_i,
  output logic [63:0] rad_o,
  output logic [33:0] rem_o,
  output logic [31:0] root_o
);

  logic [34:0] acc;
  logic [34:0] trial;
  logic        ge;
  logic [63:0] rad_d, rad_q;
  logic [33:0] rem_d, rem_q;
  logic [31:0] root_d, root_q;

  // The incoming remainder never exceeds twice the partial root, which has
  // at most 31 bits before the last step, so its low 33 bits carry it all.
  always_comb begin
    acc    = {rem_i[32:0], rad_i[63:62]};
    trial  = {1'b0, root_i, 2'b01};
    ge     = (acc >= trial);
    rem_d  = ge ? 34'(acc - trial) : acc[33:0];
    root_d = {root_i[30:0], ge};
    rad_d  = {rad_i[61:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// ===== design/ssc_div_cell.sv =====
// ----------------------------------------------------------------------------
// ssc_div_cell: one quotient bit of a restoring division
// Shifts in one numerator bit, subtracts the divisor when it fits.
// ----------------------------------------------------------------------------
module ssc_div_cell import ssc_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] num_i,
  input  logic [31:0] rem_i,
  input  logic [31:0] quo_i,
  input  logic [31:0] den_i,
  output logic [63:0] num_o,
  output logic [31:0] rem_o,
  output logic [31:0] quo_o,
  output logic [31:0] den_o
);

  logic [32:0] acc;
  logic        ge;
  logic [63:0] num_q;
  logic [31:0] rem_d, rem_q, quo_q, den_q;

  always_comb begin
    acc   = {rem_i, num_i[63]};
    ge    = (acc >= {1'b0, den_i});
    rem_d = ge ? 32'(acc - {1'b0, den_i}) : acc[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= {num_i[62:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_i[30:0], ge};
      den_q <= den_i;
    end
  end

  assign num_o = num_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;
  assign den_o = den_q;

endmodule

// ===== design/sphere_sphere_collision.sv =====
// ----------------------------------------------------------------------------
// sphere_sphere_collision: streaming sphere against sphere overlap test
// Tests probe spheres against one configured collider and gives the contact
// normal and contact point of every hit.
// ----------------------------------------------------------------------------
// The block takes one probe word per clock cycle while the output register is
// empty or being read, and gives one result word per probe, in order. The
// pipeline is 68 registers deep. Its depth is set by the two chains of cells:
// 32 square-root cells, each settling one bit of the centre distance, and
// then 32 divider cells per lane (six lanes: three contact offsets and three
// normal components), each settling one quotient bit. Three front stages
// form the centre difference, the squares and the hit compare, and a last
// stage rounds, adds the collider centre, saturates and holds the result
// word. The whole pipeline advances together whenever the output register
// is empty or being read, so a probe is taken in every cycle that the
// consumer takes a result. The collider centre and radius are written
// through the plain register port and should be changed only while no
// probe is in flight. A probe whose squared centre distance is not strictly
// below the squared radius sum gives a word with is_hit low and all other
// fields zero; coincident centres give a zero normal and the collider centre
// as contact point.
// ----------------------------------------------------------------------------
module sphere_sphere_collision import ssc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic [30:0]        probe_radius_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               is_hit_o,
  output logic signed [31:0] hit_pos_x_o,
  output logic signed [31:0] hit_pos_y_o,
  output logic signed [31:0] hit_pos_z_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic signed [15:0] normal_z_o
);

  // Configuration registers.
  logic signed [2:0][31:0] centre_q;
  logic [30:0]             radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_q <= '0;
      radius_q <= 31'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgCentreX: centre_q[0] <= cfg_data_i;
        CfgCentreY: centre_q[1] <= cfg_data_i;
        CfgCentreZ: centre_q[2] <= cfg_data_i;
        CfgRadius:  radius_q    <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Flow control: every stage moves when the output register can move.
  logic                 adv;
  logic [NumStages-1:0] vld_q;

  assign adv        = !vld_q[NumStages-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  // Stage 1: per-axis difference as sign and magnitude, and the radius sum.
  logic [2:0][31:0] pt;
  logic [2:0][32:0] mag1_q;
  logic [2:0]       neg1_q;
  logic [31:0]      rsum1_q;

  assign pt = {point_z_i, point_y_i, point_x_i};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        logic signed [32:0] diff;
        diff      = 33'(signed'(pt[a])) - 33'(signed'(centre_q[a]));
        neg1_q[a] <= diff[32];
        mag1_q[a] <= diff[32] ? 33'(-diff) : 33'(diff);
      end
      rsum1_q <= 32'(probe_radius_i) + 32'(radius_q);
    end
  end

  // Stage 2: squares of the differences and of the radius sum. A magnitude
  // is at most 2^32 - 1, so its low 32 bits carry it whole.
  logic [2:0][64:0] sq2_q;
  logic [63:0]      rs2_q;
  logic [2:0][32:0] mag2_q;
  logic [2:0]       neg2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        logic [63:0] sq;
        sq        = mag1_q[a][31:0] * mag1_q[a][31:0];
        sq2_q[a] <= {1'b0, sq};
      end
      rs2_q  <= rsum1_q * rsum1_q;
      mag2_q <= mag1_q;
      neg2_q <= neg1_q;
    end
  end

  // Stage 3: distance square, strict compare, and the offset numerators.
  logic [66:0] dsum;
  logic [63:0] dist3_q;
  sqrt_side_t  side3_q;

  assign dsum = 67'(sq2_q[0]) + 67'(sq2_q[1]) + 67'(sq2_q[2]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist3_q      <= dsum[63:0];
      side3_q.hit  <= (dsum < 67'(rs2_q));
      side3_q.neg  <= neg2_q;
      side3_q.mag  <= mag2_q;
      for (int a = 0; a < 3; a++) begin
        logic [63:0] prod;
        prod             = mag2_q[a][31:0] * radius_q;
        side3_q.prod[a] <= prod;
      end
    end
  end

  // Square-root chain: one root bit per cell.
  logic [63:0] sq_rad  [0:SqrtSteps];
  logic [33:0] sq_rem  [0:SqrtSteps];
  logic [31:0] sq_root [0:SqrtSteps];
  sqrt_side_t  sq_side [0:SqrtSteps];

  assign sq_rad[0]  = dist3_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = side3_q;

  for (genvar s = 0; s < SqrtSteps; s++) begin : g_sqrt
    sqrt_side_t side_q;

    ssc_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rad_i  (sq_rad[s]),
      .rem_i  (sq_rem[s]),
      .root_i (sq_root[s]),
      .rad_o  (sq_rad[s+1]),
      .rem_o  (sq_rem[s+1]),
      .root_o (sq_root[s+1])
    );

    always_ff @(posedge clk_i) begin
      if (adv) begin
        side_q <= sq_side[s];
      end
    end
    assign sq_side[s+1] = side_q;
  end

  // Divider lanes: offsets scaled by the collider radius, then the normal.
  logic [NumLanes-1:0][63:0] dv_num [0:DivSteps];
  logic [NumLanes-1:0][31:0] dv_rem [0:DivSteps];
  logic [NumLanes-1:0][31:0] dv_quo [0:DivSteps];
  logic [NumLanes-1:0][31:0] dv_den [0:DivSteps];
  div_side_t                 dv_side [0:DivSteps];

  for (genvar a = 0; a < 3; a++) begin : g_lane_in
    logic [63:0] nnum;
    assign nnum = {17'd0, sq_side[SqrtSteps].mag[a], 14'd0};
    assign dv_num[0][a]     = {sq_side[SqrtSteps].prod[a][31:0], 32'd0};
    assign dv_rem[0][a]     = sq_side[SqrtSteps].prod[a][63:32];
    assign dv_num[0][a+3]   = {nnum[31:0], 32'd0};
    assign dv_rem[0][a+3]   = nnum[63:32];
  end
  for (genvar l = 0; l < NumLanes; l++) begin : g_lane_den
    assign dv_quo[0][l] = '0;
    assign dv_den[0][l] = sq_root[SqrtSteps];
  end
  assign dv_side[0].hit = sq_side[SqrtSteps].hit;
  assign dv_side[0].neg = sq_side[SqrtSteps].neg;

  for (genvar s = 0; s < DivSteps; s++) begin : g_div
    div_side_t side_q;

    for (genvar l = 0; l < NumLanes; l++) begin : g_lane
      ssc_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (adv),
        .num_i (dv_num[s][l]),
        .rem_i (dv_rem[s][l]),
        .quo_i (dv_quo[s][l]),
        .den_i (dv_den[s][l]),
        .num_o (dv_num[s+1][l]),
        .rem_o (dv_rem[s+1][l]),
        .quo_o (dv_quo[s+1][l]),
        .den_o (dv_den[s+1][l])
      );
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        side_q <= dv_side[s];
      end
    end
    assign dv_side[s+1] = side_q;
  end

  // Output stage: round to nearest, apply sign, add centre, saturate.
  logic                    hit_d, hit_q;
  logic signed [2:0][31:0] pos_d, pos_q;
  logic signed [2:0][15:0] nrm_d, nrm_q;
  logic [31:0]             len;

  assign len = dv_den[DivSteps][0];

  always_comb begin
    hit_d = dv_side[DivSteps].hit;
    pos_d = '0;
    nrm_d = '0;
    for (int a = 0; a < 3; a++) begin
      logic [32:0]        qo, qn;
      logic signed [33:0] off, sum;
      qo  = {1'b0, dv_quo[DivSteps][a]} +
            33'({dv_rem[DivSteps][a], 1'b0} >= {1'b0, len});
      qn  = {1'b0, dv_quo[DivSteps][a+3]} +
            33'({dv_rem[DivSteps][a+3], 1'b0} >= {1'b0, len});
      off = dv_side[DivSteps].neg[a] ? -signed'({1'b0, qo}) : signed'({1'b0, qo});
      if (len == '0) begin
        off = '0;
      end
      sum = 34'(signed'(centre_q[a])) + off;
      if (hit_d) begin
        if (sum > 34'sh7FFFFFFF) begin
          pos_d[a] = 32'h7FFFFFFF;
        end else if (sum < -34'sh80000000) begin
          pos_d[a] = 32'h80000000;
        end else begin
          pos_d[a] = sum[31:0];
        end
        if (len != '0) begin
          nrm_d[a] = dv_side[DivSteps].neg[a] ? 16'(-qn[15:0]) : qn[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q <= hit_d;
      pos_q <= pos_d;
      nrm_q <= nrm_d;
    end
  end

  assign out_valid_o = vld_q[NumStages-1];
  assign is_hit_o    = hit_q;
  assign hit_pos_x_o = pos_q[0];
  assign hit_pos_y_o = pos_q[1];
  assign hit_pos_z_o = pos_q[2];
  assign normal_x_o  = nrm_q[0];
  assign normal_y_o  = nrm_q[1];
  assign normal_z_o  = nrm_q[2];

endmodule
